[hw/rtl/lru_key_value_cache_assert.svh]
// ----------------------------------------------------------------------------
// lru_key_value_cache_assert.svh
// Assertion macros for the LRU key/value cache; clocked on clk_i, reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check a property outside of reset.
`define LKVC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define LKVC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define LKVC_ASSERT(lbl, prop, msg)
`define LKVC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[hw/rtl/lkvc_pkg.sv]
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared sizes, codes and types of the LRU key/value cache.
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned AgeW     = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned CfgW     = 5;
  localparam int unsigned WordW    = 32;

  typedef logic [WordW-1:0]    word_t;
  typedef logic [AgeW-1:0]     age_t;
  typedef logic [CntW-1:0]     cnt_t;
  typedef logic [Capacity-1:0] vec_t;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  // Lookup outcome handed from the match logic to the update logic.
  typedef struct packed {
    logic  hit;
    vec_t  hit_vec;
    age_t  hit_age;
    word_t hit_data;
    vec_t  free_vec;
    vec_t  old_vec;
  } lookup_t;

endpackage

`default_nettype wire

[hw/rtl/lkvc_lookup.sv]
// ----------------------------------------------------------------------------
// lkvc_lookup
// Parallel key match, free-entry pick and least-recent pick over all entries.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_lookup (
  input  lkvc_pkg::word_t   key_i,
  input  lkvc_pkg::vec_t    valid_i,
  input  lkvc_pkg::word_t   keys_i [lkvc_pkg::Capacity],
  input  lkvc_pkg::word_t   data_i [lkvc_pkg::Capacity],
  input  lkvc_pkg::age_t    ages_i [lkvc_pkg::Capacity],
  input  lkvc_pkg::cnt_t    fill_i,
  output lkvc_pkg::lookup_t res_o
);

  lkvc_pkg::cnt_t oldest_rank;

  // The least recent valid entry holds the rank fill - 1.
  assign oldest_rank = fill_i - lkvc_pkg::cnt_t'(1);

  always_comb begin
    res_o = '0;
    for (int i = 0; i < lkvc_pkg::Capacity; i++) begin
      res_o.hit_vec[i] = valid_i[i] && (keys_i[i] == key_i);
      res_o.old_vec[i] = valid_i[i] && ({1'b0, ages_i[i]} == oldest_rank);
    end
    // Keys are unique among valid entries, so an and-or select suffices.
    for (int i = 0; i < lkvc_pkg::Capacity; i++) begin
      res_o.hit_data = res_o.hit_data | (data_i[i] & {lkvc_pkg::WordW{res_o.hit_vec[i]}});
      res_o.hit_age  = res_o.hit_age  | (ages_i[i] & {lkvc_pkg::AgeW{res_o.hit_vec[i]}});
    end
    res_o.hit      = |res_o.hit_vec;
    // Lowest clear bit of the valid vector.
    res_o.free_vec = ~valid_i & (valid_i + lkvc_pkg::vec_t'(1));
  end

endmodule

`default_nettype wire

[hw/rtl/lru_key_value_cache.sv]
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake               payload
//   in        sink       in_valid_i/in_ready_o   in_op_i, in_key_i, in_value_i
//   out       source     out_valid_o/out_ready_i out_found_o, out_read_value_o
//   cfg       sink       cfg_we_i (no wait)      cfg_wdata_i (capacity)
//
// One beat per cycle while no get stalls: an accepted beat sits in the stage
// register, where the parallel match over all sixteen entries and the age update
// complete, so the entry state is current for the very next beat.
// A get yields one out beat through the result register; a put yields none.
// A get stalls in the stage only while the out register holds an untaken beat.
// Reset empties the store at once: valid bits, ages and fill count clear, the
// capacity returns to sixteen. No clearing pass.
//
`default_nettype none
`include "lru_key_value_cache_assert.svh"

module lru_key_value_cache (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       in_op_i,
  input  logic signed [31:0]         in_key_i,
  input  logic signed [31:0]         in_value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       out_found_o,
  output logic signed [31:0]         out_read_value_o,
  input  logic                       cfg_we_i,
  input  logic [lkvc_pkg::CfgW-1:0]  cfg_wdata_i
);

  // Configuration.
  logic [lkvc_pkg::CfgW-1:0] cap_q;
  lkvc_pkg::cnt_t            eff_cap;

  // Stage register.
  logic            stage_v_q;
  lkvc_pkg::op_e   stage_op_q;
  lkvc_pkg::word_t stage_key_q;
  lkvc_pkg::word_t stage_value_q;

  // Entry state.
  lkvc_pkg::vec_t  valid_q;
  lkvc_pkg::word_t keys_q [lkvc_pkg::Capacity];
  lkvc_pkg::word_t data_q [lkvc_pkg::Capacity];
  lkvc_pkg::age_t  ages_q [lkvc_pkg::Capacity];
  lkvc_pkg::cnt_t  fill_q;

  // Result register.
  logic            out_v_q;
  logic            out_found_q;
  lkvc_pkg::word_t out_data_q;

  lkvc_pkg::lookup_t lk;
  logic              stage_retire;
  logic              is_put;
  logic              insert_free;
  logic              do_update;
  lkvc_pkg::vec_t    write_vec;
  lkvc_pkg::cnt_t    age_thr;

  // Clamp the capacity into one to sixteen.
  always_comb begin
    priority if (cap_q == '0) begin
      eff_cap = lkvc_pkg::cnt_t'(1);
    end else if (cap_q > lkvc_pkg::CfgW'(lkvc_pkg::Capacity)) begin
      eff_cap = lkvc_pkg::cnt_t'(lkvc_pkg::Capacity);
    end else begin
      eff_cap = lkvc_pkg::cnt_t'(cap_q);
    end
  end

  lkvc_lookup u_lookup (
    .key_i   (stage_key_q),
    .valid_i (valid_q),
    .keys_i  (keys_q),
    .data_i  (data_q),
    .ages_i  (ages_q),
    .fill_i  (fill_q),
    .res_o   (lk)
  );

  // A put always retires; a get retires when the out register can take it.
  assign is_put       = (stage_op_q == lkvc_pkg::OP_PUT);
  assign stage_retire = stage_v_q && (is_put || !out_v_q || out_ready_i);
  assign in_ready_o   = !stage_v_q || stage_retire;

  assign insert_free = !lk.hit && (fill_q < eff_cap);
  assign do_update   = stage_retire && (is_put || lk.hit);

  // Pick the target entry and the age below which valid entries grow older.
  always_comb begin
    priority if (lk.hit) begin
      write_vec = lk.hit_vec;
      age_thr   = {1'b0, lk.hit_age};
    end else if (insert_free) begin
      write_vec = lk.free_vec;
      age_thr   = lkvc_pkg::cnt_t'(lkvc_pkg::Capacity);
    end else begin
      write_vec = lk.old_vec;
      age_thr   = fill_q - lkvc_pkg::cnt_t'(1);
    end
  end

  // Capacity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkvc_pkg::CfgW'(lkvc_pkg::Capacity);
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Stage register: load a new beat, or drop the retired one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      stage_v_q <= 1'b1;
    end else if (stage_retire) begin
      stage_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      stage_op_q    <= lkvc_pkg::op_e'(in_op_i);
      stage_key_q   <= lkvc_pkg::word_t'(in_key_i);
      stage_value_q <= lkvc_pkg::word_t'(in_value_i);
    end
  end

  // Control part of the entry state: valid bits, ages, fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      fill_q  <= '0;
      for (int i = 0; i < lkvc_pkg::Capacity; i++) begin
        ages_q[i] <= '0;
      end
    end else if (do_update) begin
      for (int i = 0; i < lkvc_pkg::Capacity; i++) begin
        if (write_vec[i]) begin
          ages_q[i] <= '0;
        end else if (valid_q[i] && ({1'b0, ages_q[i]} < age_thr)) begin
          ages_q[i] <= ages_q[i] + lkvc_pkg::age_t'(1);
        end
      end
      if (is_put) begin
        valid_q <= valid_q | write_vec;
        if (insert_free) begin
          fill_q <= fill_q + lkvc_pkg::cnt_t'(1);
        end
      end
    end
  end

  // Keys and data: write the target entry on a put.
  always_ff @(posedge clk_i) begin
    if (do_update && is_put) begin
      for (int i = 0; i < lkvc_pkg::Capacity; i++) begin
        if (write_vec[i]) begin
          keys_q[i] <= stage_key_q;
          data_q[i] <= stage_value_q;
        end
      end
    end
  end

  // Result register: advance a get, hold until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (stage_retire && !is_put) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_retire && !is_put) begin
      out_found_q <= lk.hit;
      out_data_q  <= lk.hit ? lk.hit_data : '1;
    end
  end

  assign out_valid_o      = out_v_q;
  assign out_found_o      = out_found_q;
  assign out_read_value_o = $signed(out_data_q);

  `LKVC_ASSERT(a_fill_matches_valid, $countones(valid_q) == fill_q, "fill count out of step")
  `LKVC_ASSERT(a_insert_grows_fill,
    stage_retire && is_put && insert_free |=> fill_q == $past(fill_q) + lkvc_pkg::cnt_t'(1),
    "insert did not grow the fill count")
  `LKVC_ASSERT(a_get_gives_beat, stage_retire && !is_put |=> out_v_q, "get lost its result")
  `LKVC_ASSERT(a_fill_bounded, fill_q <= lkvc_pkg::cnt_t'(lkvc_pkg::Capacity),
    "fill count above depth")
  `LKVC_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> fill_q == '0 && !out_v_q,
    "store not empty in reset")

endmodule

`default_nettype wire

[dv/lru_key_value_cache_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_checker
// Watches the in, out and cfg ports of the LRU key/value cache, keeps its own
// copy of the store with recency ranks, and compares every read beat in order.
// ----------------------------------------------------------------------------

module lru_key_value_cache_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic                      in_op_i,
  input  lkvc_pkg::word_t           in_key_i,
  input  lkvc_pkg::word_t           in_value_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic                      out_found_i,
  input  lkvc_pkg::word_t           out_read_value_i,
  input  logic                      cfg_we_i,
  input  logic [lkvc_pkg::CfgW-1:0] cfg_wdata_i,
  output int unsigned               mismatch_cnt_o,
  output int unsigned               open_reads_o,
  output int unsigned               lookup_cnt_o,
  output int unsigned               hit_cnt_o
);

  localparam int unsigned MaxPrints = 40;

  typedef struct packed {
    logic            found;
    lkvc_pkg::word_t data;
  } read_reply_t;

  logic                      slot_used [lkvc_pkg::Capacity];
  lkvc_pkg::word_t           slot_key  [lkvc_pkg::Capacity];
  lkvc_pkg::word_t           slot_data [lkvc_pkg::Capacity];
  int unsigned               slot_rank [lkvc_pkg::Capacity];
  int unsigned               fill;
  logic [lkvc_pkg::CfgW-1:0] capacity_q;

  read_reply_t     open_reads_q[$];
  int unsigned     mismatches;
  int unsigned     lookups;
  int unsigned     hits;

  task automatic report_mismatch(input string what, input lkvc_pkg::word_t got,
                                 input lkvc_pkg::word_t want);
    if (mismatches < MaxPrints) begin
      $display("%0t checker: %s got %h expected %h", $time, what, got, want);
    end
    mismatches++;
  endtask

  // Zero acts as one, anything above the store size saturates.
  function automatic int unsigned usable_slots();
    if (capacity_q == '0) return 1;
    if (capacity_q > lkvc_pkg::Capacity) return lkvc_pkg::Capacity;
    return capacity_q;
  endfunction

  // Make a slot the most recent; every slot younger than it ages by one.
  task automatic promote(input int slot);
    int unsigned r;
    r = slot_rank[slot];
    for (int i = 0; i < lkvc_pkg::Capacity; i++) begin
      if (slot_used[i] && slot_rank[i] < r) slot_rank[i]++;
    end
    slot_rank[slot] = 0;
  endtask

  task automatic lru_lookup_update(input lkvc_pkg::op_e op, input lkvc_pkg::word_t key,
                                   input lkvc_pkg::word_t value,
                                   output logic gives_read, output read_reply_t reply);
    int slot;
    int victim;
    slot         = -1;
    victim       = -1;
    gives_read   = 1'b0;
    reply.found  = 1'b0;
    reply.data   = '1;
    for (int i = 0; i < lkvc_pkg::Capacity; i++) begin
      if (slot < 0 && slot_used[i] && slot_key[i] == key) slot = i;
    end
    if (op == lkvc_pkg::OP_GET) begin
      gives_read = 1'b1;
      if (slot >= 0) begin
        promote(slot);
        reply.found = 1'b1;
        reply.data  = slot_data[slot];
      end
    end else if (slot >= 0) begin
      slot_data[slot] = value;
      promote(slot);
    end else begin
      if (fill < usable_slots()) begin
        for (int i = 0; i < lkvc_pkg::Capacity; i++) begin
          if (victim < 0 && !slot_used[i]) victim = i;
        end
      end
      if (victim >= 0) begin
        for (int i = 0; i < lkvc_pkg::Capacity; i++) begin
          if (slot_used[i]) slot_rank[i]++;
        end
        slot_used[victim] = 1'b1;
        slot_key[victim]  = key;
        slot_data[victim] = value;
        slot_rank[victim] = 0;
        fill++;
      end else begin
        for (int i = 0; i < lkvc_pkg::Capacity; i++) begin
          if (slot_used[i] && (victim < 0 || slot_rank[i] > slot_rank[victim])) victim = i;
        end
        if (victim >= 0) begin
          slot_key[victim]  = key;
          slot_data[victim] = value;
          promote(victim);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic        gives_read;
    read_reply_t want;
    if (!rst_ni) begin
      for (int i = 0; i < lkvc_pkg::Capacity; i++) begin
        slot_used[i] = 1'b0;
        slot_key[i]  = '0;
        slot_data[i] = '0;
        slot_rank[i] = 0;
      end
      fill       = 0;
      capacity_q = lkvc_pkg::CfgW'(lkvc_pkg::Capacity);
      open_reads_q.delete();
      mismatches = 0;
      lookups    = 0;
      hits       = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (open_reads_q.size() == 0) begin
          report_mismatch("read beat with nothing pending:", out_read_value_i, '1);
        end else begin
          want = open_reads_q.pop_front();
          if (out_found_i !== want.found) begin
            report_mismatch("found", lkvc_pkg::word_t'(out_found_i),
                            lkvc_pkg::word_t'(want.found));
          end
          if (out_read_value_i !== want.data) begin
            report_mismatch("read_value", out_read_value_i, want.data);
          end
        end
      end
      if (cfg_we_i) capacity_q = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        lru_lookup_update(lkvc_pkg::op_e'(in_op_i), in_key_i, in_value_i, gives_read, want);
        if (gives_read) begin
          open_reads_q.push_back(want);
          lookups++;
          if (want.found) hits++;
        end
      end
    end
    mismatch_cnt_o <= mismatches;
    open_reads_o   <= open_reads_q.size();
    lookup_cnt_o   <= lookups;
    hit_cnt_o      <= hits;
  end

endmodule

[dv/lru_key_value_cache_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_tb
// Drives gets and puts into the LRU key/value cache under a series of
// capacity settings, with random gaps on both channels and one long stall of
// the read side; a separate checker predicts and compares every read beat.
// ----------------------------------------------------------------------------

module lru_key_value_cache_tb;

  localparam int unsigned HalfPeriod    = 5;
  localparam int unsigned PhaseCount    = 9;
  localparam int unsigned ItemsPerPhase = 136;
  localparam int unsigned PoolMax       = 24;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned LongHold      = 200;
  localparam int unsigned CycleLimit    = 600_000;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic                      in_op_i;
  lkvc_pkg::word_t           in_key_i;
  lkvc_pkg::word_t           in_value_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic                      out_found_o;
  lkvc_pkg::word_t           out_read_value_o;
  logic                      cfg_we_i;
  logic [lkvc_pkg::CfgW-1:0] cfg_wdata_i;

  int unsigned mismatch_cnt;
  int unsigned open_reads;
  int unsigned lookup_cnt;
  int unsigned hit_cnt;

  // Stimulus bookkeeping and the knobs shared with the read-side process.
  int unsigned     cycle_cnt = 0;
  int unsigned     beats_sent = 0;
  int unsigned     cap_writes = 0;
  bit              calm = 1'b0;          // no idling on either side
  bit              hold_request = 1'b0;  // ask the read side for one long stall
  lkvc_pkg::word_t key_pool [PoolMax];
  int unsigned     pool_size = 1;

  always begin
    #(HalfPeriod) clk_i = 1'b1;
    #(HalfPeriod) clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  lru_key_value_cache dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .in_op_i          (in_op_i),
    .in_key_i         (in_key_i),
    .in_value_i       (in_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_found_o      (out_found_o),
    .out_read_value_o (out_read_value_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  lru_key_value_cache_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_op_i          (in_op_i),
    .in_key_i         (in_key_i),
    .in_value_i       (in_value_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_found_i      (out_found_o),
    .out_read_value_i (out_read_value_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .mismatch_cnt_o   (mismatch_cnt),
    .open_reads_o     (open_reads),
    .lookup_cnt_o     (lookup_cnt),
    .hit_cnt_o        (hit_cnt)
  );

  // Mostly back-to-back, sometimes a short gap, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Keys come mostly from a small pool so lookups hit and puts update or
  // evict; the rest are the signed extremes, zero, all ones or fully random words.
  function automatic lkvc_pkg::word_t pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return key_pool[$urandom_range(0, pool_size - 1)];
    if (r < 75) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return '1;
        default: return '0;
      endcase
    end
    return $urandom;
  endfunction

  function automatic lkvc_pkg::word_t pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [lkvc_pkg::CfgW-1:0] phase_capacity(input int unsigned p);
    case (p)
      0:       return 5'd1;
      1:       return 5'd16;
      2:       return 5'd31;
      3:       return 5'd5;
      4:       return 5'd3;
      5:       return 5'd16;
      6:       return 5'd9;
      7:       return 5'd2;
      default: return 5'd12;
    endcase
  endfunction

  // Offer one beat and hold it until accepted; keep valid high into the
  // next beat when no gap follows, so it is never dropped and raised in one step.
  task automatic send_beat(input lkvc_pkg::op_e op, input lkvc_pkg::word_t key,
                           input lkvc_pkg::word_t value);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_op_i    <= op;
    in_key_i   <= key;
    in_value_i <= value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    beats_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid, then wait for every pending read and let the pipeline drain
  // any trailing put, which leaves no beat behind to wait on.
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (open_reads != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [lkvc_pkg::CfgW-1:0] cap);
    drain_pipeline();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cap_writes++;
  endtask

  // Read side: random stalls of the same shape as the input gaps, plus one
  // long hold on request while the input side keeps offering beats, which
  // fills the stage and out registers and pushes back on in_ready_o.
  initial begin : read_side
    int unsigned idle;
    int unsigned busy;
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_request) begin
        out_ready_i <= 1'b0;
        for (int unsigned c = 0; c < LongHold; c++) @(posedge clk_i);
        hold_request = 1'b0;
      end else begin
        idle = pick_gap();
        if (idle != 0) begin
          out_ready_i <= 1'b0;
          repeat (idle) @(posedge clk_i);
        end
        out_ready_i <= 1'b1;
        busy = $urandom_range(1, 12);
        repeat (busy) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    wait (cycle_cnt >= CycleLimit);
    $display("timeout after %0d cycles, %0d reads still pending", cycle_cnt, open_reads);
    $display("lru_key_value_cache_tb: errors");
    $finish;
  end

  initial begin : stimulus
    in_valid_i  <= 1'b0;
    in_op_i     <= lkvc_pkg::OP_GET;
    in_key_i    <= '0;
    in_value_i  <= '0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    rst_ni      <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset capacity: empty-store miss, signed extreme keys and values,
    // update in place, and a stored -1 that must still read as found.
    send_beat(lkvc_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_beat(lkvc_pkg::OP_PUT, 32'h8000_0000, 32'h7fff_ffff);
    send_beat(lkvc_pkg::OP_PUT, 32'h7fff_ffff, 32'h8000_0000);
    send_beat(lkvc_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);
    send_beat(lkvc_pkg::OP_GET, 32'h7fff_ffff, 32'hffff_ffff);
    send_beat(lkvc_pkg::OP_PUT, 32'h8000_0000, 32'h0000_0000);
    send_beat(lkvc_pkg::OP_GET, 32'h8000_0000, 32'h1234_5678);
    send_beat(lkvc_pkg::OP_PUT, 32'hffff_ffff, 32'hffff_ffff);
    send_beat(lkvc_pkg::OP_GET, 32'hffff_ffff, 32'h0000_0000);
    send_beat(lkvc_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);

    // Capacity lowered below the fill count: new keys replace the least
    // recent entry and the fill count holds at three.
    write_capacity(5'd2);
    send_beat(lkvc_pkg::OP_PUT, 32'h0000_0000, 32'h0000_0005);
    send_beat(lkvc_pkg::OP_GET, 32'h7fff_ffff, 32'h0000_0000);
    send_beat(lkvc_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_beat(lkvc_pkg::OP_PUT, 32'h0000_0001, 32'h0000_0001);
    send_beat(lkvc_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);
    send_beat(lkvc_pkg::OP_GET, 32'hffff_ffff, 32'h0000_0000);

    // Capacity zero behaves as one.
    write_capacity(5'd0);
    send_beat(lkvc_pkg::OP_PUT, 32'h0000_0009, 32'h0000_0009);
    send_beat(lkvc_pkg::OP_PUT, 32'h0000_000a, 32'h0000_000a);
    send_beat(lkvc_pkg::OP_GET, 32'h0000_0009, 32'h0000_0000);
    send_beat(lkvc_pkg::OP_GET, 32'h0000_000a, 32'h0000_0000);
    send_beat(lkvc_pkg::OP_PUT, 32'h0000_000a, 32'h0000_000b);
    send_beat(lkvc_pkg::OP_GET, 32'h0000_000a, 32'h0000_0000);

    // Random phases: fresh key pool per phase, a mix of gets and puts.
    for (int unsigned p = 0; p < PhaseCount; p++) begin
      write_capacity(phase_capacity(p));
      pool_size = $urandom_range(1, PoolMax);
      for (int unsigned i = 0; i < pool_size; i++) key_pool[i] = $urandom;
      calm = (p == 3 || p == 6);
      if (p == 1) hold_request = 1'b1;
      for (int unsigned n = 0; n < ItemsPerPhase; n++) begin
        if ($urandom_range(0, 1) != 0) begin
          send_beat(lkvc_pkg::OP_GET, pick_key(), pick_value());
        end else begin
          send_beat(lkvc_pkg::OP_PUT, pick_key(), pick_value());
        end
      end
    end

    drain_pipeline();
    $display("summary: %0d beats in, %0d reads checked (%0d hits), %0d capacity writes",
             beats_sent, lookup_cnt, hit_cnt, cap_writes);
    $display("summary: capacities 0 through 31 incl. shrink below fill, one %0d-cycle read stall",
             LongHold);
    if (mismatch_cnt == 0) begin
      $display("lru_key_value_cache_tb: clean");
    end else begin
      $display("lru_key_value_cache_tb: errors");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/lkvc_pkg.sv
hw/rtl/lkvc_lookup.sv
hw/rtl/lru_key_value_cache.sv
dv/lru_key_value_cache_checker.sv
dv/lru_key_value_cache_tb.sv
